>>> design/swlm_pkg.sv
package swlm_pkg;

  typedef struct packed {
    logic       mode;
    logic [3:0] key_code;
  } in_t;

  typedef struct packed {
    logic [31:0] elapsed_tenths;
    logic        is_running;
    logic        is_paused;
    logic        memory_view;
    logic        entering_number;
    logic [4:0]  saved_count;
    logic [3:0]  shown_index;
    logic [31:0] shown_time;
    logic        shown_valid;
    logic [1:0]  buzzer;
  } out_t;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_KEY  = 1'b1;

  localparam logic [3:0] KEY_A    = 4'd10;
  localparam logic [3:0] KEY_B    = 4'd11;
  localparam logic [3:0] KEY_C    = 4'd12;
  localparam logic [3:0] KEY_D    = 4'd13;
  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  typedef enum logic [1:0] {
    BEEP_NONE   = 2'd0,
    BEEP_SHORT  = 2'd1,
    BEEP_LONG   = 2'd2,
    BEEP_DOUBLE = 2'd3
  } beep_t;

  localparam int TENTHS_PER_MIN = 600;
  localparam int MIN_PER_HOUR   = 60;
  localparam int DIGIT_BASE     = 10;
  // two-digit lap number, up to 99
  localparam int ENTRY_W        = 7;

  typedef struct packed {
    logic inc;
    logic clr;
  } timer_ctl_t;

  typedef struct packed {
    logic  running;
    logic  paused;
    logic  view;
    logic  entry;
    beep_t key_beep;
  } ctrl_stat_t;

endpackage

>>> design/stopwatch_with_lap_memory_unit.sv
// A result is valid the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; in_stall rises only while a result is held
// by out_stall in the output register.
// Reset: rst synchronous, active high; clears count, flags, lap count and index.
// Lap memory contents are not cleared and are never shown until written.
module stopwatch_with_lap_memory_unit #(
  parameter int LAP_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  swlm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output swlm_pkg::out_t out_data
);

  localparam int CW = $clog2(LAP_SLOTS + 1);
  localparam int IW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
  localparam int MW = (CW > 5) ? CW : 5;

  logic                 accept;
  swlm_pkg::timer_ctl_t tctl;
  swlm_pkg::ctrl_stat_t stat;
  logic [31:0]          elapsed;
  logic                 minute_change;
  logic [CW-1:0]        lap_count;
  logic [IW-1:0]        view_index;
  logic [31:0]          lap_time;
  swlm_pkg::beep_t      buzzer;
  swlm_pkg::beep_t      buzzer_next;
  logic [MW-1:0]        count_ext;
  logic [MW-1:0]        index_ext;
  logic                 shown_valid;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign tctl.inc = accept && (in_data.mode == swlm_pkg::MODE_TICK) && stat.running;
  assign tctl.clr = accept && (in_data.mode == swlm_pkg::MODE_KEY) &&
                    (in_data.key_code == swlm_pkg::KEY_C);

  swlm_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .ctl           (tctl),
    .elapsed       (elapsed),
    .minute_change (minute_change)
  );

  swlm_ctrl #(.LAP_SLOTS(LAP_SLOTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_data    (in_data),
    .elapsed    (elapsed),
    .stat       (stat),
    .lap_count  (lap_count),
    .view_index (view_index),
    .lap_time   (lap_time)
  );

  always_comb begin
    if (in_data.mode == swlm_pkg::MODE_KEY) begin
      buzzer_next = stat.key_beep;
    end else if (stat.running && minute_change) begin
      buzzer_next = swlm_pkg::BEEP_LONG;
    end else begin
      buzzer_next = swlm_pkg::BEEP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buzzer <= buzzer_next;
    end
  end

  assign count_ext   = MW'(lap_count);
  assign index_ext   = MW'(view_index);
  assign shown_valid = stat.view && (lap_count != '0);

  assign out_data.elapsed_tenths  = elapsed;
  assign out_data.is_running      = stat.running;
  assign out_data.is_paused       = stat.paused;
  assign out_data.memory_view     = stat.view;
  assign out_data.entering_number = stat.entry;
  assign out_data.saved_count     = count_ext[4:0];
  assign out_data.shown_index     = index_ext[3:0];
  assign out_data.shown_time      = shown_valid ? lap_time : 32'd0;
  assign out_data.shown_valid     = shown_valid;
  assign out_data.buzzer          = buzzer;

endmodule

>>> design/swlm_timer.sv
module swlm_timer (
  input  logic                  clk,
  input  logic                  rst,
  input  swlm_pkg::timer_ctl_t  ctl,
  output logic [31:0]           elapsed,
  output logic                  minute_change
);

  logic [9:0] sub;
  logic [5:0] minute;
  logic [5:0] last_minute;

  assign minute_change = (minute != last_minute);

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed     <= '0;
      sub         <= '0;
      minute      <= '0;
      last_minute <= '0;
    end else if (ctl.clr) begin
      elapsed <= '0;
      sub     <= '0;
      minute  <= '0;
    end else if (ctl.inc) begin
      elapsed     <= elapsed + 32'd1;
      last_minute <= minute;
      if (&elapsed) begin
        sub    <= '0;
        minute <= '0;
      end else if (sub == 10'(swlm_pkg::TENTHS_PER_MIN - 1)) begin
        sub    <= '0;
        minute <= (minute == 6'(swlm_pkg::MIN_PER_HOUR - 1)) ? 6'd0 : minute + 6'd1;
      end else begin
        sub <= sub + 10'd1;
      end
    end
  end

endmodule

>>> design/swlm_ctrl.sv
module swlm_ctrl #(
  parameter  int LAP_SLOTS = 16,
  localparam int CW = $clog2(LAP_SLOTS + 1),
  localparam int IW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  swlm_pkg::in_t         in_data,
  input  logic [31:0]           elapsed,
  output swlm_pkg::ctrl_stat_t  stat,
  output logic [CW-1:0]         lap_count,
  output logic [IW-1:0]         view_index,
  output logic [31:0]           lap_time
);

  localparam int MW0 = (CW > swlm_pkg::ENTRY_W) ? CW : swlm_pkg::ENTRY_W;
  localparam int MW  = (MW0 > IW + 1) ? MW0 : IW + 1;

  logic [31:0] store [LAP_SLOTS];
  logic [31:0] last_saved;

  logic          running, paused, view, entry;
  logic [3:0]    first_digit;
  logic          running_next, paused_next, view_next, entry_next;
  logic [3:0]    first_digit_next;
  logic [CW-1:0] lap_count_next;
  logic [IW-1:0] view_index_next, idx_keyed;
  swlm_pkg::beep_t beep;
  logic          lap_we;

  logic [MW-1:0] pick_sum, count_ext, idx_inc;
  logic          pick_bad, save_ok;
  logic [IW-1:0] pick_idx;
  swlm_pkg::beep_t pick_beep;
  logic [IW-1:0] lap_waddr;

  always_comb begin
    count_ext = MW'(lap_count);
    if (in_data.key_code == swlm_pkg::KEY_HASH) begin
      pick_sum = MW'(first_digit);
    end else begin
      pick_sum = MW'(first_digit) * MW'(swlm_pkg::DIGIT_BASE) + MW'(in_data.key_code);
    end
    pick_bad  = (lap_count == '0) || (pick_sum == '0) || (pick_sum > count_ext);
    pick_idx  = pick_bad ? '0 : IW'(pick_sum - MW'(1));
    pick_beep = pick_bad ? swlm_pkg::BEEP_LONG : swlm_pkg::BEEP_DOUBLE;
    idx_inc   = MW'(view_index) + MW'(1);
    save_ok   = (lap_count < CW'(LAP_SLOTS)) &&
                ((lap_count == '0) || (last_saved != elapsed));
  end

  always_comb begin
    running_next     = running;
    paused_next      = paused;
    view_next        = view;
    entry_next       = entry;
    first_digit_next = first_digit;
    lap_count_next   = lap_count;
    idx_keyed        = view_index;
    beep             = swlm_pkg::BEEP_NONE;
    lap_we           = 1'b0;
    if (in_data.mode == swlm_pkg::MODE_KEY) begin
      case (in_data.key_code)
        swlm_pkg::KEY_D: begin
          running_next = !running;
          paused_next  = running;
          beep         = swlm_pkg::BEEP_SHORT;
        end
        swlm_pkg::KEY_C: begin
          running_next = 1'b0;
          paused_next  = 1'b0;
          beep         = swlm_pkg::BEEP_SHORT;
        end
        swlm_pkg::KEY_STAR: begin
          if (entry) begin
            entry_next = 1'b0;
            beep       = swlm_pkg::BEEP_LONG;
          end else begin
            lap_count_next = '0;
            view_next      = 1'b0;
            beep           = swlm_pkg::BEEP_SHORT;
          end
        end
        swlm_pkg::KEY_HASH: begin
          if (entry) begin
            idx_keyed  = pick_idx;
            beep       = pick_beep;
            entry_next = 1'b0;
          end else if (save_ok) begin
            lap_we         = 1'b1;
            lap_count_next = lap_count + CW'(1);
            beep           = swlm_pkg::BEEP_SHORT;
          end
        end
        swlm_pkg::KEY_A: begin
          view_next = !view;
          beep      = swlm_pkg::BEEP_SHORT;
        end
        swlm_pkg::KEY_B: begin
          if (view) begin
            if (idx_inc == count_ext || idx_inc >= MW'(LAP_SLOTS)) begin
              idx_keyed = '0;
            end else begin
              idx_keyed = IW'(idx_inc);
            end
            beep = swlm_pkg::BEEP_SHORT;
          end
        end
        default: begin
          if (view) begin
            if (!entry) begin
              first_digit_next = in_data.key_code;
              entry_next       = 1'b1;
              beep             = swlm_pkg::BEEP_SHORT;
            end else begin
              idx_keyed  = pick_idx;
              beep       = pick_beep;
              entry_next = 1'b0;
            end
          end
        end
      endcase
    end
    if (view_next && lap_count_next != '0 && MW'(idx_keyed) >= MW'(lap_count_next)) begin
      view_index_next = '0;
    end else begin
      view_index_next = idx_keyed;
    end
  end

  assign lap_waddr = lap_count[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      paused      <= 1'b0;
      view        <= 1'b0;
      entry       <= 1'b0;
      first_digit <= '0;
      lap_count   <= '0;
      view_index  <= '0;
    end else if (accept) begin
      running     <= running_next;
      paused      <= paused_next;
      view        <= view_next;
      entry       <= entry_next;
      first_digit <= first_digit_next;
      lap_count   <= lap_count_next;
      view_index  <= view_index_next;
    end
  end

  // lap memory; a save and a read of the same slot forward the new word
  always_ff @(posedge clk) begin
    if (accept && lap_we) begin
      store[lap_waddr] <= elapsed;
      last_saved       <= elapsed;
    end
    if (accept) begin
      if (lap_we && lap_waddr == view_index_next) begin
        lap_time <= elapsed;
      end else begin
        lap_time <= store[view_index_next];
      end
    end
  end

  assign stat.running  = running;
  assign stat.paused   = paused;
  assign stat.view     = view;
  assign stat.entry    = entry;
  assign stat.key_beep = beep;

endmodule

>>> design/swlm_checker.sv
module swlm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input swlm_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input swlm_pkg::out_t out_data
);

  a_held_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled transaction changed");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  a_run_pause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_running && out_data.is_paused))
    else $error("running and paused together");

  a_shown_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.shown_valid |-> out_data.memory_view)
    else $error("lap shown outside view mode");

  a_shown_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.shown_valid |-> out_data.shown_time == 32'd0)
    else $error("shown time not zero without a valid lap");

endmodule

bind stopwatch_with_lap_memory_unit swlm_checker u_swlm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
